// ----- sv/uhid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uhid_pkg
// Shared constants and types for the HID boot interface descriptor parser.
// ----------------------------------------------------------------------------
package uhid_pkg;

    localparam logic [7:0] TYPE_INTERFACE = 8'h04;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
    localparam logic [7:0] CLASS_HID      = 8'h03;
    localparam logic [7:0] SUBCLASS_BOOT  = 8'h01;
    localparam logic [7:0] ATTR_INTERRUPT = 8'h03;
    localparam logic [7:0] NO_INTERFACE   = 8'hFF;
    localparam logic [7:0] PROTOCOL_RESET = 8'h01;

    // byte offsets inside a sub-descriptor
    localparam logic [7:0] OFS_EP_LAST    = 8'd6;
    localparam logic [7:0] OFS_IF_LAST    = 8'd7;
    localparam logic [7:0] LEN_EP_MIN     = 8'd7;
    localparam logic [7:0] LEN_IF_MIN     = 8'd8;

    // bytes at offsets 1..6 are kept
    localparam int CAP_DEPTH = 6;

    typedef struct packed {
        logic        found;
        logic [7:0]  interface_number;
        logic [6:0]  endpoint_number;
        logic [15:0] max_packet_size;
        logic [7:0]  poll_interval;
        logic        malformed;
    } report_t;

endpackage
`default_nettype wire

// ----- sv/uhid_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uhid_if
// Valid/ready channels of the descriptor parser: bytes, reports, config.
// ----------------------------------------------------------------------------
interface uhid_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface uhid_report_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [7:0]  interface_number;
    logic [6:0]  endpoint_number;
    logic [15:0] max_packet_size;
    logic [7:0]  poll_interval;
    logic        malformed;

    modport source (output valid, output found, output interface_number,
                    output endpoint_number, output max_packet_size,
                    output poll_interval, output malformed, input ready);
    modport sink   (input valid, input found, input interface_number,
                    input endpoint_number, input max_packet_size,
                    input poll_interval, input malformed, output ready);
endinterface

interface uhid_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] wanted_protocol;

    modport source (output valid, output wanted_protocol, input ready);
    modport sink   (input valid, input wanted_protocol, output ready);
endinterface
`default_nettype wire

// ----- sv/uhid_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uhid_core
// Descriptor walk state: offset, length, kept bytes, match and capture.
// ----------------------------------------------------------------------------
module uhid_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire logic [7:0]      data_byte,
    input  wire logic            final_byte,
    input  wire logic [7:0]      wanted_protocol,
    output uhid_pkg::report_t    report
);

    logic [7:0]  offset_reg,    offset_next;
    logic [7:0]  length_reg,    length_next;
    logic [7:0]  matched_reg,   matched_next;
    logic        found_reg,     found_next;
    logic [6:0]  endpoint_reg,  endpoint_next;
    logic [15:0] packet_reg,    packet_next;
    logic [7:0]  interval_reg,  interval_next;
    logic        bad_reg,       bad_next;
    logic [7:0]  cap_reg  [uhid_pkg::CAP_DEPTH];
    logic [7:0]  cap_next [uhid_pkg::CAP_DEPTH];

    // walk values after this beat, before the end-of-buffer clear
    logic [7:0]  p_offset, p_length, p_matched, p_interval;
    logic        p_found, p_bad;
    logic [6:0]  p_endpoint;
    logic [15:0] p_packet;
    logic [8:0]  offset_inc;
    logic        if_hit, ep_hit;

    always_comb
    begin
        p_offset   = offset_reg;
        p_length   = length_reg;
        p_matched  = matched_reg;
        p_found    = found_reg;
        p_endpoint = endpoint_reg;
        p_packet   = packet_reg;
        p_interval = interval_reg;
        p_bad      = bad_reg;
        cap_next   = cap_reg;
        offset_inc = {1'b0, offset_reg} + 9'd1;

        if_hit = (offset_reg == uhid_pkg::OFS_IF_LAST)
              && (length_reg >= uhid_pkg::LEN_IF_MIN)
              && (cap_reg[0] == uhid_pkg::TYPE_INTERFACE)
              && (cap_reg[4] == uhid_pkg::CLASS_HID)
              && (cap_reg[5] == uhid_pkg::SUBCLASS_BOOT)
              && (data_byte == wanted_protocol);
        ep_hit = (offset_reg == uhid_pkg::OFS_EP_LAST)
              && (length_reg >= uhid_pkg::LEN_EP_MIN)
              && (cap_reg[0] == uhid_pkg::TYPE_ENDPOINT)
              && (cap_reg[2] == uhid_pkg::ATTR_INTERRUPT)
              && (matched_reg != uhid_pkg::NO_INTERFACE);

        if (!bad_reg)
        begin
            if (offset_reg == 8'd0)
            begin
                // length byte opens a sub-descriptor
                p_length = data_byte;
                if (data_byte == 8'd0)
                begin
                    p_bad = 1'b1;
                end
                else if (data_byte > 8'd1)
                begin
                    p_offset = 8'd1;
                end
            end
            else
            begin
                for (int i = 0; i < uhid_pkg::CAP_DEPTH; i++)
                begin
                    if (offset_reg == 8'(i + 1))
                    begin
                        cap_next[i] = data_byte;
                    end
                end
                if (if_hit)
                begin
                    p_matched = cap_reg[1];
                end
                if (ep_hit)
                begin
                    p_endpoint = cap_reg[1][6:0];
                    p_packet   = {cap_reg[4], cap_reg[3]};
                    p_interval = data_byte;
                    p_found    = 1'b1;
                end
                p_offset = (offset_inc >= {1'b0, length_reg}) ? 8'd0 : offset_inc[7:0];
            end
        end
    end

    always_comb
    begin
        report.found            = p_found;
        report.interface_number = p_matched;
        report.endpoint_number  = p_endpoint;
        report.max_packet_size  = p_packet;
        report.poll_interval    = p_interval;
        report.malformed        = p_bad;
    end

    always_comb
    begin
        offset_next   = offset_reg;
        length_next   = length_reg;
        matched_next  = matched_reg;
        found_next    = found_reg;
        endpoint_next = endpoint_reg;
        packet_next   = packet_reg;
        interval_next = interval_reg;
        bad_next      = bad_reg;
        if (step_en)
        begin
            if (final_byte)
            begin
                offset_next   = 8'd0;
                length_next   = 8'd0;
                matched_next  = uhid_pkg::NO_INTERFACE;
                found_next    = 1'b0;
                endpoint_next = 7'd0;
                packet_next   = 16'd0;
                interval_next = 8'd0;
                bad_next      = 1'b0;
            end
            else
            begin
                offset_next   = p_offset;
                length_next   = p_length;
                matched_next  = p_matched;
                found_next    = p_found;
                endpoint_next = p_endpoint;
                packet_next   = p_packet;
                interval_next = p_interval;
                bad_next      = p_bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= 8'd0;
            length_reg   <= 8'd0;
            matched_reg  <= uhid_pkg::NO_INTERFACE;
            found_reg    <= 1'b0;
            endpoint_reg <= 7'd0;
            packet_reg   <= 16'd0;
            interval_reg <= 8'd0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            offset_reg   <= offset_next;
            length_reg   <= length_next;
            matched_reg  <= matched_next;
            found_reg    <= found_next;
            endpoint_reg <= endpoint_next;
            packet_reg   <= packet_next;
            interval_reg <= interval_next;
            bad_reg      <= bad_next;
        end
    end

    // kept bytes are read only after being written in the same descriptor
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            cap_reg <= cap_next;
        end
    end

    a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (offset_reg != 8'd0) |-> (offset_reg < length_reg))
        else $error("descriptor offset past its length");

    a_bad_parks_walk: assert property (@(posedge clk) disable iff (!rst_n)
        bad_reg |-> (offset_reg == 8'd0))
        else $error("walk moved after zero length byte");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && final_byte) |=>
            (!found_reg && !bad_reg && (matched_reg == uhid_pkg::NO_INTERFACE)))
        else $error("state not cleared after last beat");

endmodule
`default_nettype wire

// ----- sv/usb_hid_config_descriptor_parser_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usb_hid_config_descriptor_parser_unit
// Walks a configuration descriptor byte by byte and reports the HID boot
// interface's interrupt endpoint when the last byte arrives.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        beat
//  desc     in   data_byte, final_byte                          valid & ready
//  result   out  found, interface_number, endpoint_number,      valid & ready
//                max_packet_size, poll_interval, malformed
//  cfg      in   wanted_protocol                                valid & ready
//
//  one byte per cycle unless desc stalls; a byte is registered, then walked
//  the report for a last byte is valid once that byte has passed the input
//  register and its walk result has been loaded into the report register
//  desc stalls only when a last byte waits while an unread report is held
//  rst_n clears the walk state; wanted_protocol resets to 1
// ----------------------------------------------------------------------------
module usb_hid_config_descriptor_parser_unit
(
    input  wire logic clk,
    input  wire logic rst_n,
    uhid_byte_if.sink     desc,
    uhid_report_if.source result,
    uhid_cfg_if.sink      cfg
);

    logic                stage_valid_reg, stage_valid_next;
    logic [7:0]          stage_byte_reg;
    logic                stage_final_reg;
    logic                out_valid_reg, out_valid_next;
    uhid_pkg::report_t   out_data_reg;
    uhid_pkg::report_t   report;
    logic [7:0]          protocol_reg;
    logic                advance;
    logic                step_en;
    logic                take_in;

    assign advance = !(stage_valid_reg && stage_final_reg && out_valid_reg && !result.ready);
    assign step_en = stage_valid_reg && advance;
    assign desc.ready = !stage_valid_reg || advance;
    assign take_in = desc.valid && desc.ready;
    assign cfg.ready = 1'b1;

    uhid_core u_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (step_en),
        .data_byte       (stage_byte_reg),
        .final_byte      (stage_final_reg),
        .wanted_protocol (protocol_reg),
        .report          (report)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take_in)
        begin
            stage_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_en && stage_final_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            protocol_reg    <= uhid_pkg::PROTOCOL_RESET;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cfg.valid)
            begin
                protocol_reg <= cfg.wanted_protocol;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            stage_byte_reg  <= desc.data_byte;
            stage_final_reg <= desc.final_byte;
        end
        if (step_en && stage_final_reg)
        begin
            out_data_reg <= report;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.found            = out_data_reg.found;
    assign result.interface_number = out_data_reg.interface_number;
    assign result.endpoint_number  = out_data_reg.endpoint_number;
    assign result.max_packet_size  = out_data_reg.max_packet_size;
    assign result.poll_interval    = out_data_reg.poll_interval;
    assign result.malformed        = out_data_reg.malformed;

    a_report_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_valid_reg && stage_final_reg))
        else $error("report raised without a last byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !(step_en && stage_final_reg))
        else $error("pending report overwritten");

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !stage_final_reg) |-> step_en)
        else $error("ordinary byte held in input register");

endmodule
`default_nettype wire
